@@ src/base64_stream_codec_assert.svh @@
// Assertion helpers for the base64 stream codec.
// Both sample on clk and are disabled while arst_n is low.
`ifndef BASE64_STREAM_CODEC_ASSERT_SVH
`define BASE64_STREAM_CODEC_ASSERT_SVH

// Same-cycle implication.
`define B64SC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define B64SC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/b64sc_pkg.sv @@
`timescale 1ns / 1ps
package b64sc_pkg;

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	// Decoded character classes beyond the 64 alphabet values
	localparam logic [6:0] SYM_PAD = 7'd64;
	localparam logic [6:0] SYM_BAD = 7'd127;

	localparam logic [7:0] CHAR_PAD = 8'h3D;

	localparam int QDEPTH = 2;
	localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [7:0] in_symbol;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_symbol;
		logic       out_last;
		logic       bad_input;
	} out_item_t;

	// One group of work handed from the front end to the serializer
	typedef struct packed {
		logic        mode;
		logic [23:0] bits;
		logic [2:0]  cnt;
		logic [1:0]  npad;
		logic        last;
		logic        bad;
	} job_t;

	function automatic logic [7:0] enc_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26)      return 8'h41 + w;
		else if (v < 6'd52) return 8'd71 + w;
		else if (v < 6'd62) return w - 8'd4;
		else if (v == 6'd62) return 8'h2B;
		else return 8'h2F;
	endfunction

	function automatic logic [6:0] dec_char(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c inside {[8'h41:8'h5A]}) begin
			d = c - 8'h41;
			return d[6:0];
		end else if (c inside {[8'h61:8'h7A]}) begin
			d = c - 8'd71;
			return d[6:0];
		end else if (c inside {[8'h30:8'h39]}) begin
			d = c + 8'd4;
			return d[6:0];
		end else if (c == 8'h2B) begin
			return 7'd62;
		end else if (c == 8'h2F) begin
			return 7'd63;
		end else if (c == CHAR_PAD) begin
			return SYM_PAD;
		end
		return SYM_BAD;
	endfunction

endpackage

@@ src/b64sc_queue.sv @@
`timescale 1ns / 1ps
module b64sc_queue
	import b64sc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  job_t             push_job,
	input  logic             pop,
	output job_t             head,
	output logic             full,
	output logic             nonempty,
	output logic [QCW-1:0]   count
);

	job_t             slot_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (cnt_q == QCW'(QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign count    = cnt_q;
	assign head     = slot_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ src/b64sc_front.sv @@
`timescale 1ns / 1ps
module b64sc_front
	import b64sc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       dir,
	input  logic       clr,
	input  logic       acc,
	input  in_item_t   item,
	output logic       push,
	output job_t       job,
	output logic [1:0] fill
);

	logic [17:0] bits_q, bits_n;
	logic [1:0]  fill_q, fill_n;
	logic [1:0]  pad_q, pad_n;
	logic        err_q, err_n;

	logic [23:0] g_enc;
	logic [2:0]  fill_inc;
	logic [6:0]  v;
	logic [5:0]  s;
	logic [23:0] t_dec;

	assign g_enc    = {bits_q[15:0], item.in_symbol};
	assign fill_inc = {1'b0, fill_q} + 3'd1;
	assign v        = dec_char(item.in_symbol);
	assign fill     = fill_q;

	always_comb begin
		bits_n = bits_q;
		fill_n = fill_q;
		pad_n  = pad_q;
		err_n  = err_q;
		push   = 1'b0;
		job    = '0;
		s      = 6'd0;
		t_dec  = 24'd0;
		job.mode = dir;
		job.last = item.in_last;
		if (dir == DIR_ENCODE) begin
			job.cnt = 3'd4;
			if (fill_inc >= 3'd3) begin
				push     = 1'b1;
				job.bits = g_enc;
				job.npad = 2'd0;
				bits_n   = '0;
				fill_n   = '0;
				pad_n    = '0;
				err_n    = 1'b0;
			end else if (item.in_last) begin
				// pad the short group: two '=' after one byte, one after two
				push     = 1'b1;
				job.bits = (fill_q == 2'd0) ? {item.in_symbol, 16'h0000}
				                            : {g_enc[15:0], 8'h00};
				job.npad = (fill_q == 2'd0) ? 2'd2 : 2'd1;
				bits_n   = '0;
				fill_n   = '0;
				pad_n    = '0;
				err_n    = 1'b0;
			end else begin
				bits_n = g_enc[17:0];
				fill_n = fill_inc[1:0];
			end
		end else begin
			if (v == SYM_PAD) begin
				if (fill_q < 2'd2) err_n = 1'b1;
				else pad_n = pad_q + 2'd1;
			end else if (v == SYM_BAD) begin
				err_n = 1'b1;
			end else begin
				s = v[5:0];
				if (pad_q != 2'd0) err_n = 1'b1;
			end
			t_dec = {bits_q, s};
			if (fill_q == 2'd3) begin
				if (pad_n != 2'd0 && !item.in_last) err_n = 1'b1;
				push     = 1'b1;
				job.bits = t_dec;
				job.cnt  = 3'd3 - ((pad_n > 2'd2) ? 3'd2 : {1'b0, pad_n});
				job.bad  = err_n;
				bits_n   = '0;
				fill_n   = '0;
				pad_n    = '0;
				if (item.in_last) err_n = 1'b0;
			end else if (item.in_last) begin
				// truncated message: one flagged zero byte closes it
				push     = 1'b1;
				job.bits = '0;
				job.cnt  = 3'd1;
				job.bad  = 1'b1;
				bits_n   = '0;
				fill_n   = '0;
				pad_n    = '0;
				err_n    = 1'b0;
			end else begin
				bits_n = t_dec[17:0];
				fill_n = fill_q + 2'd1;
			end
		end
		if (!acc) push = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
			fill_q <= '0;
			pad_q  <= '0;
			err_q  <= 1'b0;
		end else if (clr) begin
			bits_q <= '0;
			fill_q <= '0;
			pad_q  <= '0;
			err_q  <= 1'b0;
		end else if (acc) begin
			bits_q <= bits_n;
			fill_q <= fill_n;
			pad_q  <= pad_n;
			err_q  <= err_n;
		end
	end

endmodule

@@ src/b64sc_back.sv @@
`timescale 1ns / 1ps
module b64sc_back
	import b64sc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  job_t      head,
	input  logic      head_valid,
	output logic      pop,
	output logic      busy,
	output logic      dst_valid,
	input  logic      dst_stall,
	output out_item_t dst_data
);

	job_t       cur_q;
	logic       cur_valid_q;
	logic [1:0] idx_q;
	logic       out_valid_q;
	out_item_t  out_q;

	logic       advance;
	logic       last_idx;
	logic [5:0] sextet;
	logic [7:0] byte_sel;
	logic       is_pad;
	out_item_t  nxt;

	assign advance  = !out_valid_q || !dst_stall;
	assign last_idx = ({1'b0, idx_q} + 3'd1) == cur_q.cnt;
	assign pop      = head_valid && (!cur_valid_q || (advance && last_idx));
	assign busy     = cur_valid_q;

	always_comb begin
		case (idx_q)
			2'd0: begin
				sextet   = cur_q.bits[23:18];
				byte_sel = cur_q.bits[23:16];
			end
			2'd1: begin
				sextet   = cur_q.bits[17:12];
				byte_sel = cur_q.bits[15:8];
			end
			2'd2: begin
				sextet   = cur_q.bits[11:6];
				byte_sel = cur_q.bits[7:0];
			end
			default: begin
				sextet   = cur_q.bits[5:0];
				byte_sel = 8'h00;
			end
		endcase
		is_pad = (cur_q.npad == 2'd2 && idx_q >= 2'd2) || (cur_q.npad == 2'd1 && idx_q == 2'd3);
		nxt.out_last  = cur_q.last && last_idx;
		nxt.bad_input = cur_q.bad;
		if (cur_q.mode == DIR_ENCODE) begin
			nxt.out_symbol = is_pad ? CHAR_PAD : enc_char(sextet);
		end else begin
			nxt.out_symbol = byte_sel;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (advance && cur_valid_q) begin
			out_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= cur_valid_q;
			end
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (advance && cur_valid_q) begin
				if (last_idx) cur_valid_q <= 1'b0;
				else idx_q <= idx_q + 2'd1;
			end
		end
	end

	assign dst_valid = out_valid_q;
	assign dst_data  = out_q;

endmodule

@@ src/base64_stream_codec.sv @@
`timescale 1ns / 1ps
// Streaming base64 codec, standard alphabet A-Z a-z 0-9 + / with '=' padding.
// Channels: src carries one symbol per transfer (src_valid/src_stall, src_data),
// dst returns one symbol per transfer (dst_valid/dst_stall, dst_data), and the
// cfg channel (cfg_valid/cfg_ready, cfg_data) sets direction: 0 encode, 1 decode.
// Change direction only while the block is idle; a write clears any partial group.
// The front end gathers a group and hands it through a two-entry job queue to a
// serializer that emits one result per cycle from a registered output while dst is not stalled.
// A completed group passes through the job queue, the serializer's job register and
// the output register on its way to dst, waiting in the queue while the serializer is busy.
// Throughput: the serializer output port sets the rate at one result per cycle unless dst stalls;
// encoding takes in three bytes for every four characters out, decoding one character a cycle.
// src_stall rises only when the job queue is full.
// Reset (arst_n low) clears all group state, empties the queue and drops dst_valid;
// direction returns to encode. A stalled dst holds its result and backs up the
// serializer, then the queue, then src.
`include "base64_stream_codec_assert.svh"
module base64_stream_codec
	import b64sc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  in_item_t  src_data,
	output logic      dst_valid,
	input  logic      dst_stall,
	output out_item_t dst_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_data
);

	logic           dir_q;
	logic           cfg_wr;
	logic           src_acc;

	logic           q_push;
	job_t           q_in;
	logic           q_pop;
	job_t           q_head;
	logic           q_full;
	logic           q_nonempty;
	logic [QCW-1:0] q_count;
	logic [1:0]     front_fill;
	logic           back_busy;

	// the register accepts a write on every cycle
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DIR_ENCODE;
		end else if (cfg_wr) begin
			dir_q <= cfg_data;
		end
	end

	// hold src only when no queue slot is free
	assign src_stall = q_full;
	assign src_acc   = src_valid && !src_stall;

	b64sc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.dir    (dir_q),
		.clr    (cfg_wr),
		.acc    (src_acc),
		.item   (src_data),
		.push   (q_push),
		.job    (q_in),
		.fill   (front_fill)
	);

	b64sc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_in),
		.pop      (q_pop),
		.head     (q_head),
		.full     (q_full),
		.nonempty (q_nonempty),
		.count    (q_count)
	);

	b64sc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.head_valid (q_nonempty),
		.pop        (q_pop),
		.busy       (back_busy),
		.dst_valid  (dst_valid),
		.dst_stall  (dst_stall),
		.dst_data   (dst_data)
	);

	`B64SC_ASSERT_NOW(a_queue_bound, 1'b1, q_count <= QCW'(QDEPTH), "job queue over depth")
	`B64SC_ASSERT_NEXT(a_last_clears, src_acc && src_data.in_last && !cfg_wr, front_fill == 2'd0, "group not cleared after last symbol")
	`B64SC_ASSERT_NEXT(a_idle_pops, q_nonempty && !back_busy, back_busy, "serializer left a queued job waiting")

endmodule

@@ tb/base64_stream_codec_test.sv @@
`timescale 1ns / 1ps
module base64_stream_codec_test;
	import b64sc_pkg::*;

	// Cycles to let the codec finish a group that produced no result yet
	localparam int SETTLE_CYCLES  = 16;
	// Cycles without any transfer before the run is declared hung
	localparam int WATCHDOG_LIMIT = 1000;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      src_valid = 1'b0;
	logic      src_stall;
	in_item_t  src_data  = '0;
	logic      dst_valid;
	logic      dst_stall = 1'b0;
	out_item_t dst_data;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic      cfg_data  = 1'b0;

	// Symbols waiting to go out on src, and codec results still owed on dst
	in_item_t  send_q[$];
	out_item_t expected_q[$];

	// Predictor state: direction plus the group being gathered
	logic        codec_dir;
	logic [17:0] grp_bits;
	logic [1:0]  grp_fill;
	logic [1:0]  pad_cnt;
	logic        err_flag;

	int n_fail      = 0;
	int idle_cycles = 0;
	int src_gap     = 0;
	int stall_left  = 0;
	bit src_calm    = 1'b0;
	bit dst_calm    = 1'b0;

	base64_stream_codec i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_data(src_data),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_data(dst_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Map a sextet to its character in the standard alphabet
	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		if (v < 6'd26) begin
			return 8'h41 + 8'(v);
		end else if (v < 6'd52) begin
			return 8'h61 + 8'(v - 6'd26);
		end else if (v < 6'd62) begin
			return 8'h30 + 8'(v - 6'd52);
		end else if (v == 6'd62) begin
			return 8'h2B;
		end
		return 8'h2F;
	endfunction

	// Classify a character: its sextet, the pad class, or the illegal class.
	// Search the alphabet rather than decode by ranges.
	function automatic logic [6:0] char_class(input logic [7:0] c);
		for (int k = 0; k < 64; k++) begin
			if (sextet_char(6'(k)) == c) begin
				return 7'(k);
			end
		end
		if (c == CHAR_PAD) begin
			return SYM_PAD;
		end
		return SYM_BAD;
	endfunction

	function automatic void clear_codec_group();
		grp_bits = '0;
		grp_fill = '0;
		pad_cnt  = '0;
		err_flag = 1'b0;
	endfunction

	function automatic void owe_result(input logic [7:0] sym, input logic last,
			input logic bad);
		out_item_t r;
		r.out_symbol = sym;
		r.out_last   = last;
		r.bad_input  = bad;
		expected_q.push_back(r);
	endfunction

	// Advance the predictor by one accepted symbol and queue what it yields
	function automatic void predict_transfer(input in_item_t it);
		logic [23:0] g;
		logic [23:0] t;
		logic [6:0]  cls;
		logic [5:0]  sx;
		logic [1:0]  pos;
		int          cnt;
		if (codec_dir == DIR_ENCODE) begin
			g = {grp_bits[15:0], it.in_symbol};
			if (grp_fill == 2'd2) begin
				// Full group of three bytes: four characters, no pad
				owe_result(sextet_char(g[23:18]), 1'b0, 1'b0);
				owe_result(sextet_char(g[17:12]), 1'b0, 1'b0);
				owe_result(sextet_char(g[11:6]), 1'b0, 1'b0);
				owe_result(sextet_char(g[5:0]), it.in_last, 1'b0);
				clear_codec_group();
			end else if (it.in_last) begin
				// Short final group: zero-fill and pad out to four characters
				t = (grp_fill == 2'd0) ? {it.in_symbol, 16'h0000} : {g[15:0], 8'h00};
				owe_result(sextet_char(t[23:18]), 1'b0, 1'b0);
				owe_result(sextet_char(t[17:12]), 1'b0, 1'b0);
				owe_result((grp_fill == 2'd0) ? CHAR_PAD : sextet_char(t[11:6]),
					1'b0, 1'b0);
				owe_result(CHAR_PAD, 1'b1, 1'b0);
				clear_codec_group();
			end else begin
				grp_bits = g[17:0];
				grp_fill = grp_fill + 2'd1;
			end
		end else begin
			pos = grp_fill;
			cls = char_class(it.in_symbol);
			sx  = '0;
			if (cls == SYM_PAD) begin
				// Pad only counts in the last two slots of a group
				if (pos < 2'd2) begin
					err_flag = 1'b1;
				end else begin
					pad_cnt = pad_cnt + 2'd1;
				end
			end else if (cls == SYM_BAD) begin
				err_flag = 1'b1;
			end else begin
				sx = cls[5:0];
				// Data after a pad in the same group is malformed
				if (pad_cnt != 2'd0) begin
					err_flag = 1'b1;
				end
			end
			t = {grp_bits, sx};
			if (pos == 2'd3) begin
				// Padded group must close the message
				if (pad_cnt != 2'd0 && !it.in_last) begin
					err_flag = 1'b1;
				end
				cnt = 3 - ((pad_cnt > 2'd2) ? 2 : int'(pad_cnt));
				for (int k = 0; k < cnt; k++) begin
					owe_result(t[23 - 8 * k -: 8], (k == cnt - 1) ? it.in_last : 1'b0,
						err_flag);
				end
				if (it.in_last) begin
					clear_codec_group();
				end else begin
					grp_bits = '0;
					grp_fill = '0;
					pad_cnt  = '0;
				end
			end else if (it.in_last) begin
				// Message ends inside a group: one flagged filler result
				owe_result(8'h00, 1'b1, 1'b1);
				clear_codec_group();
			end else begin
				grp_bits = t[17:0];
				grp_fill = pos + 2'd1;
			end
		end
	endfunction

	// Source driver: hold each symbol until it transfers, then idle a drawn gap
	always @(posedge clk) begin : drive_src
		logic     take;
		logic     nxt_valid;
		in_item_t nxt_data;
		if (!arst_n) begin
			src_valid <= 1'b0;
			src_data  <= '0;
			src_gap   <= 0;
		end else begin
			take      = src_valid && !src_stall;
			nxt_valid = src_valid && !take;
			nxt_data  = src_data;
			if (take) begin
				predict_transfer(src_data);
			end
			if (!nxt_valid) begin
				if (src_gap != 0) begin
					src_gap <= src_gap - 1;
				end else if (send_q.size() != 0) begin
					nxt_data  = send_q.pop_front();
					nxt_valid = 1'b1;
					// Switch now and then between gappy and back-to-back streaming
					if ($urandom_range(0, 23) == 0) begin
						src_calm <= !src_calm;
					end
					src_gap <= src_calm ? 0 : $urandom_range(0, 7);
				end
			end
			src_valid <= nxt_valid;
			src_data  <= nxt_data;
		end
	end

	// Result monitor: check each transfer on dst, stall at random, watch for a hang
	always @(posedge clk) begin : watch_dst
		out_item_t want;
		int        nxt_stall;
		if (!arst_n) begin
			dst_stall   <= 1'b0;
			stall_left  <= 0;
			idle_cycles <= 0;
		end else begin
			nxt_stall = (stall_left != 0) ? stall_left - 1 : 0;
			if (dst_valid && !dst_stall) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result: out_symbol %0h out_last %0b bad_input %0b",
						dst_data.out_symbol, dst_data.out_last, dst_data.bad_input);
					n_fail++;
				end else begin
					want = expected_q.pop_front();
					if (dst_data.out_symbol !== want.out_symbol) begin
						$error("out_symbol: expected %0h, actual %0h",
							want.out_symbol, dst_data.out_symbol);
						n_fail++;
					end
					if (dst_data.out_last !== want.out_last) begin
						$error("out_last: expected %0b, actual %0b",
							want.out_last, dst_data.out_last);
						n_fail++;
					end
					if (dst_data.bad_input !== want.bad_input) begin
						$error("bad_input: expected %0b, actual %0b",
							want.bad_input, dst_data.bad_input);
						n_fail++;
					end
				end
				if ($urandom_range(0, 23) == 0) begin
					dst_calm <= !dst_calm;
				end
				nxt_stall = dst_calm ? 0 : $urandom_range(0, 7);
			end else if (!dst_valid && stall_left == 0 && !dst_calm
					&& $urandom_range(0, 15) == 0) begin
				// Raise stall ahead of a result too, so it lands mid-group
				nxt_stall = $urandom_range(1, 7);
			end
			stall_left <= nxt_stall;
			dst_stall  <= (nxt_stall != 0);

			if ((src_valid && !src_stall) || (dst_valid && !dst_stall)
					|| (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("base64_stream_codec test failed");
				$finish;
			end
		end
	end

	function automatic void push_sym(input logic [7:0] s, input logic last);
		in_item_t it;
		it.in_symbol = s;
		it.in_last   = last;
		send_q.push_back(it);
	endfunction

	// Queue a text string; mark its final character as message end if asked
	function automatic void push_text(input string s, input logic last);
		for (int i = 0; i < s.len(); i++) begin
			push_sym(s[i], last && (i == s.len() - 1));
		end
	endfunction

	// One random encode message; return its length
	function automatic int queue_random_bytes();
		int len;
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 9);
		for (int i = 0; i < len; i++) begin
			push_sym(8'($urandom_range(0, 255)), i == len - 1);
		end
		return len;
	endfunction

	// One random decode message: mostly well-formed base64 of random bytes,
	// the rest noise with pads, illegal characters and ragged lengths
	function automatic int queue_random_text();
		logic [7:0]  raw[$];
		logic [23:0] w;
		int          len;
		int          rem;
		int          r;
		logic [7:0]  c;
		if ($urandom_range(0, 9) < 7) begin
			len = $urandom_range(1, 8);
			for (int i = 0; i < len; i++) begin
				raw.push_back(8'($urandom_range(0, 255)));
			end
			for (int i = 0; i < len; i += 3) begin
				rem = len - i;
				w = {raw[i], (rem > 1) ? raw[i + 1] : 8'h00, (rem > 2) ? raw[i + 2] : 8'h00};
				push_sym(sextet_char(w[23:18]), 1'b0);
				push_sym(sextet_char(w[17:12]), 1'b0);
				push_sym((rem > 1) ? sextet_char(w[11:6]) : CHAR_PAD, 1'b0);
				push_sym((rem > 2) ? sextet_char(w[5:0]) : CHAR_PAD, i + 3 >= len);
			end
			return 4 * ((len + 2) / 3);
		end
		len = $urandom_range(1, 9);
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 19);
			if (r < 14) begin
				c = sextet_char(6'($urandom_range(0, 63)));
			end else if (r < 17) begin
				c = CHAR_PAD;
			end else begin
				c = 8'($urandom_range(0, 255));
			end
			push_sym(c, i == len - 1);
		end
		return len;
	endfunction

	// Wait until every symbol has transferred and every result has come back,
	// then give the codec time to finish a group that owes nothing yet
	task automatic settle();
		while (send_q.size() != 0 || src_valid || expected_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write direction over the cfg channel; the codec drops any partial group
	task automatic write_direction(input logic dir);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= dir;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		codec_dir = dir;
		clear_codec_group();
	endtask

	initial begin : stimulus
		int n;
		codec_dir = DIR_ENCODE;
		clear_codec_group();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Encode from reset direction: one leftover byte, two leftover bytes,
		// and a full group that maps to the '+' and '/' characters
		push_sym(8'h00, 1'b1);
		push_sym(8'hFF, 1'b0);
		push_sym(8'hFF, 1'b1);
		push_sym(8'hFB, 1'b0);
		push_sym(8'hFF, 1'b0);
		push_sym(8'hBF, 1'b1);
		n = 0;
		while (n < 120) begin
			n += queue_random_bytes();
		end
		settle();

		write_direction(DIR_DECODE);
		// Two pads; early pad with illegal character; pad group not ending the
		// message followed by a short final group; data after a pad
		push_text("TQ==", 1'b1);
		push_text("=*/+", 1'b1);
		push_text("TWE=", 1'b0);
		push_text("AB", 1'b1);
		push_text("09=z", 1'b1);
		n = 0;
		while (n < 170) begin
			n += queue_random_text();
		end
		settle();

		write_direction(DIR_ENCODE);
		n = 0;
		while (n < 60) begin
			n += queue_random_bytes();
		end
		// Leave a partial group behind; the next direction write must drop it
		push_sym(8'($urandom_range(0, 255)), 1'b0);
		push_sym(8'($urandom_range(0, 255)), 1'b0);
		settle();

		write_direction(DIR_DECODE);
		n = 0;
		while (n < 120) begin
			n += queue_random_text();
		end
		settle();

		if (n_fail == 0) begin
			$display("base64_stream_codec test passed");
		end else begin
			$display("base64_stream_codec test failed");
		end
		$finish;
	end

endmodule
